@@ design/shelf_packer_worst_fit_core_macros.svh @@
// ----------------------------------------------------------------------------
// Shelf packer assertion macros
// Concurrent check wrappers, removed under synthesis.
// ----------------------------------------------------------------------------
`ifndef SHELF_PACKER_WORST_FIT_CORE_MACROS_SVH
`define SHELF_PACKER_WORST_FIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPWF_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`define SPWF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`else
`define SPWF_ASSERT_IMPLY(label, clk, rst, a, b)
`define SPWF_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ design/spwf_pkg.sv @@
// ----------------------------------------------------------------------------
// Shelf packer package
// Shared types, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package spwf_pkg;

  localparam int FIELD_BITS = 16;
  localparam int IDX_OUT_BITS = 6;
  localparam int STATUS_BITS = 2;
  localparam int REG_IDX_BITS = 2;

  localparam logic [STATUS_BITS-1:0] STATUS_PLACED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_SKIPPED = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd3;

  localparam logic [REG_IDX_BITS-1:0] REG_BIN_WIDTH  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_BIN_HEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BIN_NUMBER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctrl_t;

  typedef struct packed {
    logic en;
    logic set_base;
  } wr_ctrl_t;

endpackage

`default_nettype wire

@@ design/spwf_cell.sv @@
// ----------------------------------------------------------------------------
// Shelf cell
// Holds one shelf's base and load, and updates the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none

module spwf_cell
  import spwf_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int IDX_BITS = 6,
  parameter int CNT_BITS = 7,
  parameter int INDEX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [COORD_BITS-1:0] bin_w,
  input  wire logic [COORD_BITS-1:0] bin_h,
  input  wire logic [COORD_BITS-1:0] w,
  input  wire logic [COORD_BITS-1:0] h,
  input  wire logic [CNT_BITS-1:0]   open_cnt,
  input  wire wr_ctrl_t              wr_ctrl,
  input  wire logic [IDX_BITS-1:0]   wr_idx,
  input  wire logic [COORD_BITS-1:0] wr_load,
  input  wire logic [COORD_BITS-1:0] wr_base,
  input  wire tok_ctrl_t             in_ctrl,
  input  wire logic [COORD_BITS-1:0] in_load,
  input  wire logic [COORD_BITS-1:0] in_base,
  input  wire logic [IDX_BITS-1:0]   in_idx,
  output tok_ctrl_t                  out_ctrl,
  output logic [COORD_BITS-1:0]      out_load,
  output logic [COORD_BITS-1:0]      out_base,
  output logic [IDX_BITS-1:0]        out_idx
);

  logic [COORD_BITS-1:0] load;
  logic [COORD_BITS-1:0] base;
  logic [COORD_BITS:0]   top_sum;
  logic [COORD_BITS:0]   right_sum;
  logic                  active;
  logic                  fits;
  logic                  take;

  assign active    = in_ctrl.valid && (CNT_BITS'(INDEX) < open_cnt);
  assign top_sum   = {1'b0, base} + {1'b0, h};
  assign right_sum = {1'b0, load} + {1'b0, w};
  assign fits      = (top_sum <= {1'b0, bin_h}) && (right_sum <= {1'b0, bin_w});
  assign take      = active && fits && (!in_ctrl.found || (load < in_load));

  always_ff @(posedge clk) begin
    if (wr_ctrl.en && (wr_idx == IDX_BITS'(INDEX))) begin
      load <= wr_load;
      if (wr_ctrl.set_base) begin
        base <= wr_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl.valid <= in_ctrl.valid;
      out_ctrl.found <= in_ctrl.found || take;
    end
  end

  always_ff @(posedge clk) begin
    out_load <= take ? load : in_load;
    out_base <= take ? base : in_base;
    out_idx  <= take ? IDX_BITS'(INDEX) : in_idx;
  end

endmodule

`default_nettype wire

@@ design/shelf_packer_worst_fit_core.sv @@
// ----------------------------------------------------------------------------
// Worst-fit shelf packer core
// Places rectangles on the least loaded fitting shelf of one bin, or on a new shelf.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A placed, refused or full item waits
// until the search token, which walks the row of shelf cells one cell per
// cycle, leaves the last cell; a skipped item goes from acceptance straight
// to the finish state. A result waiting in the output register does not
// block acceptance of the next item.
`default_nettype none
`include "shelf_packer_worst_fit_core_macros.svh"

module shelf_packer_worst_fit_core
  import spwf_pkg::*;
#(
  parameter int MAX_SHELVES = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    new_bin,
  input  wire logic [FIELD_BITS-1:0]   rect_width,
  input  wire logic [FIELD_BITS-1:0]   rect_height,
  input  wire logic                    already_placed,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [STATUS_BITS-1:0]       status,
  output logic [FIELD_BITS-1:0]        pos_x,
  output logic [FIELD_BITS-1:0]        pos_y,
  output logic [IDX_OUT_BITS-1:0]      shelf_index,
  output logic [FIELD_BITS-1:0]        placed_bin,
  input  wire logic                    cfg_we,
  input  wire logic [REG_IDX_BITS-1:0] cfg_index,
  input  wire logic [FIELD_BITS-1:0]   cfg_data
);

  localparam int IDX_BITS = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_BITS = $clog2(MAX_SHELVES + 1);

  state_t                state;
  logic [FIELD_BITS-1:0] bin_width;
  logic [FIELD_BITS-1:0] bin_height;
  logic [FIELD_BITS-1:0] bin_number;
  logic [CNT_BITS-1:0]   shelves_open;
  logic [COORD_BITS-1:0] next_free_y;
  logic [COORD_BITS-1:0] w;
  logic [COORD_BITS-1:0] h;
  logic                  skip;
  logic                  head_valid;
  logic                  best_found;
  logic [COORD_BITS-1:0] best_load;
  logic [COORD_BITS-1:0] best_base;
  logic [IDX_BITS-1:0]   best_idx;

  logic [COORD_BITS-1:0] bw;
  logic [COORD_BITS-1:0] bh;
  logic                  in_fire;
  logic                  fin_fire;
  logic [COORD_BITS:0]   new_top;
  logic [31:0]           idx_wide;
  wr_ctrl_t              wr_ctrl;
  logic [IDX_BITS-1:0]   wr_idx;
  logic [COORD_BITS-1:0] wr_load;
  logic [COORD_BITS-1:0] wr_base;
  logic [STATUS_BITS-1:0] res_status;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [IDX_BITS-1:0]   res_idx;
  logic                  res_placed;

  tok_ctrl_t             chain_ctrl [0:MAX_SHELVES];
  logic [COORD_BITS-1:0] chain_load [0:MAX_SHELVES];
  logic [COORD_BITS-1:0] chain_base [0:MAX_SHELVES];
  logic [IDX_BITS-1:0]   chain_idx  [0:MAX_SHELVES];
  logic [MAX_SHELVES:0]  chain_valid;

  assign bw       = COORD_BITS'(bin_width);
  assign bh       = COORD_BITS'(bin_height);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_fire = (state == ST_FINISH) && (!out_valid || out_ready);
  assign new_top  = {1'b0, next_free_y} + {1'b0, h};

  assign chain_ctrl[0] = '{valid: head_valid, found: 1'b0};
  assign chain_load[0] = '0;
  assign chain_base[0] = '0;
  assign chain_idx[0]  = '0;

  always_comb begin
    for (int k = 0; k <= MAX_SHELVES; k++) begin
      chain_valid[k] = chain_ctrl[k].valid;
    end
  end

  for (genvar k = 0; k < MAX_SHELVES; k++) begin : g_cell
    spwf_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS),
      .INDEX      (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bin_w    (bw),
      .bin_h    (bh),
      .w        (w),
      .h        (h),
      .open_cnt (shelves_open),
      .wr_ctrl  (wr_ctrl),
      .wr_idx   (wr_idx),
      .wr_load  (wr_load),
      .wr_base  (wr_base),
      .in_ctrl  (chain_ctrl[k]),
      .in_load  (chain_load[k]),
      .in_base  (chain_base[k]),
      .in_idx   (chain_idx[k]),
      .out_ctrl (chain_ctrl[k+1]),
      .out_load (chain_load[k+1]),
      .out_base (chain_base[k+1]),
      .out_idx  (chain_idx[k+1])
    );
  end

  always_comb begin
    wr_ctrl    = '0;
    wr_idx     = best_idx;
    wr_load    = best_load + w;
    wr_base    = next_free_y;
    res_status = STATUS_PLACED;
    res_x      = '0;
    res_y      = '0;
    res_idx    = '0;
    res_placed = 1'b0;
    if (skip) begin
      res_status = STATUS_SKIPPED;
    end else if (best_found) begin
      res_x      = best_load;
      res_y      = best_base;
      res_idx    = best_idx;
      res_placed = 1'b1;
      wr_ctrl.en = fin_fire;
    end else if (new_top > {1'b0, bh}) begin
      res_status = STATUS_NO_FIT;
    end else if (shelves_open >= CNT_BITS'(MAX_SHELVES)) begin
      res_status = STATUS_FULL;
    end else begin
      res_y            = next_free_y;
      res_idx          = IDX_BITS'(shelves_open);
      res_placed       = 1'b1;
      wr_ctrl.en       = fin_fire;
      wr_ctrl.set_base = 1'b1;
      wr_idx           = IDX_BITS'(shelves_open);
      wr_load          = w;
    end
  end

  assign idx_wide = 32'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width  <= 16'hFFFF;
      bin_height <= 16'hFFFF;
      bin_number <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_WIDTH:  bin_width  <= cfg_data;
        REG_BIN_HEIGHT: bin_height <= cfg_data;
        REG_BIN_NUMBER: bin_number <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head_valid   <= 1'b0;
      shelves_open <= '0;
      next_free_y  <= '0;
      out_valid    <= 1'b0;
    end else begin
      head_valid <= in_fire && !already_placed;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (new_bin) begin
              shelves_open <= '0;
              next_free_y  <= '0;
            end
            state <= already_placed ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain_valid[MAX_SHELVES]) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            state <= ST_IDLE;
            if (wr_ctrl.set_base) begin
              shelves_open <= shelves_open + 1'b1;
              next_free_y  <= new_top[COORD_BITS-1:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w    <= COORD_BITS'(rect_width);
      h    <= COORD_BITS'(rect_height);
      skip <= already_placed;
    end
    if (state == ST_SCAN && chain_valid[MAX_SHELVES]) begin
      best_found <= chain_ctrl[MAX_SHELVES].found;
      best_load  <= chain_load[MAX_SHELVES];
      best_base  <= chain_base[MAX_SHELVES];
      best_idx   <= chain_idx[MAX_SHELVES];
    end
    if (fin_fire) begin
      status      <= res_status;
      pos_x       <= FIELD_BITS'(res_x);
      pos_y       <= FIELD_BITS'(res_y);
      shelf_index <= idx_wide[IDX_OUT_BITS-1:0];
      placed_bin  <= res_placed ? bin_number : '0;
    end
  end

  `SPWF_ASSERT_IMPLY(a_open_bound, clk, rst, 1'b1, shelves_open <= CNT_BITS'(MAX_SHELVES))
  `SPWF_ASSERT_IMPLY(a_one_token, clk, rst, 1'b1, $onehot0(chain_valid))
  `SPWF_ASSERT_IMPLY(a_token_in_scan, clk, rst, chain_valid[MAX_SHELVES], state == ST_SCAN)
  `SPWF_ASSERT_NEXT(a_result_shown, clk, rst, fin_fire, out_valid && state == ST_IDLE)

endmodule

`default_nettype wire
